@@ hw/rtl/pbu_pkg.sv @@
// Package for the clipped pixel blend unit: command and register codes,
// default store dimensions, the item record and the divide-by-255 helper.
// No dependencies.
package pbu_pkg;

  // Default store dimensions, handed to the top level as parameter defaults.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 768;

  // Field widths fixed by the interface.
  localparam int CMD_W   = 2;
  localparam int COORD_W = 16;
  localparam int PIX_W   = 32;
  localparam int ALPHA_W = 8;
  localparam int CFG_W   = 11;
  localparam int SW_W    = 11;
  localparam int SH_W    = 10;

  // Operation codes.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BLEND = 2'd2;

  // Configuration register indexes.
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Register reset values.
  localparam logic [SW_W-1:0] SCREEN_WIDTH_RST  = 11'd1024;
  localparam logic [SH_W-1:0] SCREEN_HEIGHT_RST = 10'd768;

  // Special alpha values.
  localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // One accepted item after clipping.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [PIX_W-1:0]   color;
    logic [ALPHA_W-1:0] alpha;
    logic               on_screen;
  } pbu_item_t;

  // Exact x / 255 for any x below 65280, so that the quotient fits in eight bits.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

@@ hw/rtl/pbu_if.sv @@
// Channel interfaces of the clipped pixel blend unit: item input, result
// output and configuration write. Depends on pbu_pkg.
interface pbu_in_if import pbu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic [PIX_W-1:0]           pixel_color;
  logic [ALPHA_W-1:0]         blend_alpha;

  modport source (output valid, cmd, pos_x, pos_y, pixel_color, blend_alpha, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, pixel_color, blend_alpha, output ready);
endinterface

interface pbu_out_if import pbu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] read_data;
  logic             in_bounds;

  modport source (output valid, read_data, in_bounds, input ready);
  modport sink (input valid, read_data, in_bounds, output ready);
endinterface

interface pbu_cfg_if import pbu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/clipped_pixel_blend_unit_top.sv @@
// Clipped pixel blend unit: one item at a time. An accepted item goes to S_ACC,
// then S_RD for reads and mixing blends, then S_MIX for mixing blends, and waits
// in S_DONE until the output register is free. A new item can be accepted in the
// cycle after the previous result is registered.
// Reset (synchronous, rst_n low) restores the screen registers and empties the
// pipeline; the pixel store is not cleared.
module clipped_pixel_blend_unit_top import pbu_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input logic        clk,
  input logic        rst_n,
  pbu_in_if.sink     in_bus,
  pbu_out_if.source  out_bus,
  pbu_cfg_if.sink    cfg_bus
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_RD   = 5'b00100,
    S_MIX  = 5'b01000,
    S_DONE = 5'b10000
  } pbu_state_t;

  pbu_state_t       state_r, state_nxt;
  logic [SW_W-1:0]  screen_width_r;
  logic [SH_W-1:0]  screen_height_r;
  pbu_item_t        item_r;
  logic [AW-1:0]    addr_r;
  logic             accept;
  logic             mem_we;
  logic             mem_re;
  logic [PIX_W-1:0] mem_wdata;
  logic [PIX_W-1:0] mem_rdata;
  logic [PIX_W-1:0] mixed;
  logic             mix_load;
  logic [PIX_W-1:0] result_r;
  logic             out_load;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_data_r;
  logic             out_inb_r;
  logic             is_write;
  logic             is_read;
  logic             is_mix;

  // Configuration registers; writes are taken whenever reset is released.
  assign cfg_bus.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_SCREEN_WIDTH: screen_width_r <= cfg_bus.data[SW_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_bus.data[SH_W-1:0];
        default: ;
      endcase
    end
  end

  // Only one item is in flight, so store accesses to one pixel never overlap.
  assign in_bus.ready = rst_n && (state_r == S_IDLE);
  assign accept = in_bus.valid && in_bus.ready;

  pbu_clip #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW)
  ) u_clip (
    .clk          (clk),
    .load         (accept),
    .cmd          (in_bus.cmd),
    .pos_x        (in_bus.pos_x),
    .pos_y        (in_bus.pos_y),
    .color        (in_bus.pixel_color),
    .alpha        (in_bus.blend_alpha),
    .screen_width (screen_width_r),
    .screen_height(screen_height_r),
    .item_r       (item_r),
    .addr_r       (addr_r)
  );

  // Decode what the item does to the store.
  always_comb begin
    is_write = item_r.on_screen && ((item_r.cmd == CMD_WRITE) ||
               ((item_r.cmd == CMD_BLEND) && (item_r.alpha == ALPHA_OPAQUE)));
    is_read = item_r.on_screen && (item_r.cmd == CMD_READ);
    is_mix = item_r.on_screen && (item_r.cmd == CMD_BLEND) &&
             (item_r.alpha != ALPHA_CLEAR) && (item_r.alpha != ALPHA_OPAQUE);
  end

  // Store port control: plain writes in S_ACC, mixed writes in S_MIX after the mix.
  always_comb begin
    mem_re = (state_r == S_ACC) && (is_read || is_mix);
    mem_we = ((state_r == S_ACC) && is_write) || (state_r == S_MIX);
    mem_wdata = (state_r == S_MIX) ? mixed : item_r.color;
    mix_load = (state_r == S_RD) && is_mix;
  end

  pbu_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .addr   (addr_r),
    .we     (mem_we),
    .wdata  (mem_wdata),
    .re     (mem_re),
    .rdata_r(mem_rdata)
  );

  pbu_mix u_mix (
    .clk  (clk),
    .load (mix_load),
    .src  (item_r.color),
    .dst  (mem_rdata),
    .alpha(item_r.alpha),
    .mixed(mixed)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_ACC;
      S_ACC: state_nxt = (is_read || is_mix) ? S_RD : S_DONE;
      S_RD: state_nxt = is_mix ? S_MIX : S_DONE;
      S_MIX: state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Result: zero, or the read data, held until the output register is free.
  always_ff @(posedge clk) begin
    if (state_r == S_ACC) begin
      result_r <= '0;
    end else if ((state_r == S_RD) && is_read) begin
      result_r <= mem_rdata;
    end
  end

  // Output register parts the result channel from the datapath.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result_r;
      out_inb_r <= item_r.on_screen;
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.read_data = out_data_r;
  assign out_bus.in_bounds = out_inb_r;

  // The store is only written for items inside the window.
  a_write_inside: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> item_r.on_screen)
    else $error("store written for a clipped item");

  // A read never modifies the store.
  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (item_r.cmd != CMD_READ))
    else $error("store written by a read item");

  // A clipped item always reports zero data.
  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_inb_r) |-> (out_data_r == '0))
    else $error("clipped item returned nonzero data");

  // An accepted item enters S_ACC, where any store access starts, in the next cycle.
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_ACC))
    else $error("accepted item not sequenced");

  // The store is idle while the unit waits for an item.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!mem_we && !mem_re))
    else $error("store accessed while idle");

endmodule

@@ hw/rtl/pbu_clip.sv @@
// Clip and address stage: checks an accepted item against the saturated
// screen size and registers the item with its store address. Depends on pbu_pkg.
module pbu_clip import pbu_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic [CMD_W-1:0]          cmd,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic [PIX_W-1:0]          color,
  input  logic [ALPHA_W-1:0]        alpha,
  input  logic [SW_W-1:0]           screen_width,
  input  logic [SH_W-1:0]           screen_height,
  output pbu_item_t                 item_r,
  output logic [AW-1:0]             addr_r
);

  localparam int XW  = $clog2(MAX_WIDTH + 1);
  localparam int XLW = $clog2(MAX_WIDTH);
  localparam int YLW = $clog2(MAX_HEIGHT);
  localparam int PW  = YLW + XW;

  logic [31:0]    w32;
  logic [31:0]    h32;
  logic [XW-1:0]  w_sat;
  logic           on_screen;
  logic [XLW-1:0] x_low;
  logic [YLW-1:0] y_low;
  logic [PW-1:0]  prod;
  pbu_item_t      item_nxt;
  logic [AW-1:0]  addr_nxt;

  // Saturate the window to the store size; the saturated width is the pitch.
  always_comb begin
    w32 = (32'(screen_width) < 32'(MAX_WIDTH)) ? 32'(screen_width) : 32'(MAX_WIDTH);
    h32 = (32'(screen_height) < 32'(MAX_HEIGHT)) ? 32'(screen_height) : 32'(MAX_HEIGHT);
    w_sat = XW'(w32);
  end

  // A point is inside when both coordinates are non-negative and below the window.
  always_comb begin
    on_screen = !pos_x[COORD_W-1] && !pos_y[COORD_W-1] &&
                (32'(unsigned'(pos_x)) < w32) && (32'(unsigned'(pos_y)) < h32);
    x_low = pos_x[XLW-1:0];
    y_low = pos_y[YLW-1:0];
    prod = y_low * w_sat;
    addr_nxt = AW'(prod + PW'(x_low));
    item_nxt.cmd = cmd;
    item_nxt.color = color;
    item_nxt.alpha = alpha;
    item_nxt.on_screen = on_screen;
  end

  // Item register, loaded when an item is accepted.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
      addr_r <= addr_nxt;
    end
  end

endmodule

@@ hw/rtl/pbu_store.sv @@
// Pixel store: one synchronous memory port with registered read data.
// Depends on pbu_pkg.
module pbu_store import pbu_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             we,
  input  logic [PIX_W-1:0] wdata,
  input  logic             re,
  output logic [PIX_W-1:0] rdata_r
);

  logic [PIX_W-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

endmodule

@@ hw/rtl/pbu_mix.sv @@
// Alpha mix datapath: registers s*a + d*(255-a) per channel, then divides
// each sum by 255 to form the blended pixel. Depends on pbu_pkg.
module pbu_mix import pbu_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic [PIX_W-1:0]   src,
  input  logic [PIX_W-1:0]   dst,
  input  logic [ALPHA_W-1:0] alpha,
  output logic [PIX_W-1:0]   mixed
);

  logic [15:0] sum_nxt [3];
  logic [15:0] sum_r   [3];
  logic [7:0]  inv_a;

  // Weighted sum for each of blue, green and red.
  always_comb begin
    inv_a = ALPHA_OPAQUE - alpha;
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = 16'(src[8*c +: 8] * alpha) + 16'(dst[8*c +: 8] * inv_a);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= sum_nxt;
    end
  end

  // Divide by 255 and clear the top byte.
  assign mixed = {8'h00, div255(sum_r[2]), div255(sum_r[1]), div255(sum_r[0])};

endmodule

@@ sim/clipped_pixel_blend_unit_top_test.sv @@
// Self-checking testbench for clipped_pixel_blend_unit_top: directed and random
// pixel writes, reads and blends under several screen sizes, with a shadow framebuffer.
// Depends on pbu_pkg, the pbu channel interfaces and the top-level RTL.
`timescale 1ns / 1ps

module clipped_pixel_blend_unit_top_test;
  import pbu_pkg::*;

  // The unused command code; the block must leave the store alone for it.
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  localparam int CYCLE_LIMIT        = 400000;
  localparam int RESET_CYCLES       = 6;
  localparam int PHASE_ITEMS        = 150;
  localparam int PHASE_COUNT        = 10;
  localparam int LONG_HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES      = 12;
  localparam int MAX_IDLE           = 19;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [PIX_W-1:0]          color;
    logic [ALPHA_W-1:0]        alpha;
  } pixel_op_t;

  typedef struct packed {
    logic [PIX_W-1:0] read_data;
    logic             in_bounds;
  } pixel_result_t;

  // One row of the directed table; known marks rows whose result is typed in.
  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [PIX_W-1:0]          color;
    logic [ALPHA_W-1:0]        alpha;
    logic                      known;
    logic [PIX_W-1:0]          want_data;
    logic                      want_inb;
  } directed_row_t;

  // Directed items, all at the reset screen size of 1024 by 768.
  localparam directed_row_t DIRECTED_OPS [25] = '{
    '{CMD_WRITE, 16'sd0,     16'sd0,     32'hFFFF_FFFF, ALPHA_CLEAR,  1'b1, 32'h0, 1'b1},
    '{CMD_READ,  16'sd0,     16'sd0,     32'h0,         ALPHA_CLEAR,  1'b1, 32'hFFFF_FFFF, 1'b1},
    '{CMD_WRITE, 16'sd1023,  16'sd767,   32'h1234_5678, ALPHA_CLEAR,  1'b1, 32'h0, 1'b1},
    '{CMD_READ,  16'sd1023,  16'sd767,   32'h0,         ALPHA_CLEAR,  1'b1, 32'h1234_5678, 1'b1},
    '{CMD_WRITE, 16'sd1024,  16'sd0,     32'hDEAD_BEEF, ALPHA_CLEAR,  1'b1, 32'h0, 1'b0},
    '{CMD_WRITE, 16'sd0,     16'sd768,   32'hDEAD_BEEF, ALPHA_CLEAR,  1'b1, 32'h0, 1'b0},
    '{CMD_READ,  -16'sd1,    16'sd0,     32'h0,         ALPHA_CLEAR,  1'b1, 32'h0, 1'b0},
    '{CMD_READ,  16'sd0,     -16'sd1,    32'h0,         ALPHA_CLEAR,  1'b1, 32'h0, 1'b0},
    '{CMD_READ,  16'sh8000,  16'sh8000,  32'h0,         ALPHA_CLEAR,  1'b1, 32'h0, 1'b0},
    '{CMD_READ,  16'sd32767, 16'sd32767, 32'h0,         ALPHA_CLEAR,  1'b1, 32'h0, 1'b0},
    '{CMD_BLEND, 16'sd0,     16'sd0,     32'h0,         ALPHA_CLEAR,  1'b1, 32'h0, 1'b1},
    '{CMD_READ,  16'sd0,     16'sd0,     32'h0,         ALPHA_CLEAR,  1'b1, 32'hFFFF_FFFF, 1'b1},
    '{CMD_BLEND, 16'sd0,     16'sd0,     32'h00A0_B0C0, ALPHA_OPAQUE, 1'b1, 32'h0, 1'b1},
    '{CMD_READ,  16'sd0,     16'sd0,     32'h0,         ALPHA_CLEAR,  1'b1, 32'h00A0_B0C0, 1'b1},
    '{CMD_BLEND, 16'sd0,     16'sd0,     32'hFF10_2030, 8'h80,        1'b0, 32'h0, 1'b0},
    '{CMD_READ,  16'sd0,     16'sd0,     32'h0,         ALPHA_CLEAR,  1'b0, 32'h0, 1'b0},
    '{CMD_WRITE, 16'sd1023,  16'sd0,     32'h80FF_00FF, ALPHA_CLEAR,  1'b1, 32'h0, 1'b1},
    '{CMD_BLEND, 16'sd1023,  16'sd0,     32'h7F00_FF00, 8'h01,        1'b0, 32'h0, 1'b0},
    '{CMD_READ,  16'sd1023,  16'sd0,     32'h0,         ALPHA_CLEAR,  1'b0, 32'h0, 1'b0},
    '{CMD_BLEND, 16'sd1023,  16'sd0,     32'hFFFF_FFFF, 8'hFE,        1'b0, 32'h0, 1'b0},
    '{CMD_READ,  16'sd1023,  16'sd0,     32'h0,         ALPHA_CLEAR,  1'b0, 32'h0, 1'b0},
    '{CMD_NONE,  16'sd0,     16'sd0,     32'hFFFF_FFFF, ALPHA_OPAQUE, 1'b1, 32'h0, 1'b1},
    '{CMD_NONE,  -16'sd5,    16'sd3,     32'hFFFF_FFFF, ALPHA_OPAQUE, 1'b1, 32'h0, 1'b0},
    '{CMD_BLEND, 16'sd2000,  16'sd5,     32'h0F0F_0F0F, 8'h64,        1'b1, 32'h0, 1'b0},
    '{CMD_READ,  16'sd1023,  16'sd767,   32'h0,         ALPHA_CLEAR,  1'b1, 32'h1234_5678, 1'b1}
  };

  // Screen sizes of the fixed phases: extremes, saturation, zero size, odd sizes.
  localparam logic [CFG_W-1:0] PHASE_W [8] = '{11'd16, 11'h7FF, 11'd1, 11'd0,
                                               11'd9, 11'd1024, 11'd100, 11'd1025};
  localparam logic [CFG_W-1:0] PHASE_H [8] = '{11'd12, 11'h7FF, 11'd1, 11'd5,
                                               11'd0, 11'd768, 11'd50, 11'd769};

  logic clk = 1'b0;
  logic rst_n;

  pbu_in_if  in_bus ();
  pbu_out_if out_bus ();
  pbu_cfg_if cfg_bus ();

  clipped_pixel_blend_unit_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the screen registers and of every pixel drawn so far.
  logic [SW_W-1:0]  scr_width  = SCREEN_WIDTH_RST;
  logic [SH_W-1:0]  scr_height = SCREEN_HEIGHT_RST;
  logic [PIX_W-1:0] shadow_fb [int];
  int               drawn_addrs [$];
  int               last_drawn;
  bit               last_drawn_ok;

  pixel_result_t    pending_results [$];
  int               fail_count;
  int unsigned      cycle_count;
  bit               no_idle;
  bit               long_hold_req;

  function automatic int eff_width();
    return (int'(scr_width) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(scr_width);
  endfunction

  function automatic int eff_height();
    return (int'(scr_height) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(scr_height);
  endfunction

  function automatic void store_pixel(input int addr, input logic [PIX_W-1:0] value);
    if (!shadow_fb.exists(addr)) drawn_addrs.push_back(addr);
    shadow_fb[addr] = value;
    last_drawn      = addr;
    last_drawn_ok   = 1'b1;
  endfunction

  // Clip, then apply one item to the shadow framebuffer and return its result.
  function automatic pixel_result_t predict_pixel_op(input pixel_op_t op);
    pixel_result_t    res;
    int               ew, eh, sx, sy, addr, s, d, a, ch;
    logic [PIX_W-1:0] dst, mixed;
    ew = eff_width();
    eh = eff_height();
    sx = int'(op.x);
    sy = int'(op.y);
    res.read_data = '0;
    res.in_bounds = (sx >= 0 && sy >= 0 && sx < ew && sy < eh);
    if (res.in_bounds) begin
      addr = sy * ew + sx;
      dst  = shadow_fb.exists(addr) ? shadow_fb[addr] : '0;
      case (op.cmd)
        CMD_WRITE: store_pixel(addr, op.color);
        CMD_READ:  res.read_data = dst;
        CMD_BLEND: begin
          a = int'(op.alpha);
          if (op.alpha == ALPHA_OPAQUE) begin
            store_pixel(addr, op.color);
          end else if (op.alpha != ALPHA_CLEAR) begin
            // Each color channel mixes on its own; the top byte comes out zero.
            mixed = '0;
            for (ch = 0; ch < 3; ch++) begin
              s = int'(op.color[8*ch +: 8]);
              d = int'(dst[8*ch +: 8]);
              mixed[8*ch +: 8] = 8'((s * a + d * (255 - a)) / 255);
            end
            store_pixel(addr, mixed);
          end
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // Random item. Reads and blends that land on screen only ever hit drawn pixels;
  // otherwise they get a coordinate that is sure to be clipped.
  function automatic pixel_op_t random_pixel_op();
    pixel_op_t   op;
    int          ew, eh, addr, cx, cy;
    int unsigned pick;
    bit          aimed;
    ew   = eff_width();
    eh   = eff_height();
    pick = $urandom_range(0, 99);
    op.cmd = (pick < 35) ? CMD_WRITE : (pick < 65) ? CMD_READ :
             (pick < 95) ? CMD_BLEND : CMD_NONE;
    op.color = $urandom();
    pick = $urandom_range(0, 9);
    op.alpha = (pick == 0) ? ALPHA_CLEAR : (pick == 1) ? ALPHA_OPAQUE : 8'($urandom());
    if (op.cmd == CMD_READ || op.cmd == CMD_BLEND) begin
      aimed = 1'b0;
      if (drawn_addrs.size() != 0 && ew != 0 && $urandom_range(0, 6) != 0) begin
        // Favor the pixel drawn last so that read-after-write is hit often.
        addr = (last_drawn_ok && $urandom_range(0, 2) == 0) ? last_drawn :
               drawn_addrs[$urandom_range(0, drawn_addrs.size() - 1)];
        cx    = addr % ew;
        cy    = addr / ew;
        aimed = (cy < eh);
      end
      if (!aimed) begin
        case ($urandom_range(0, 2))
          0: begin
            cx = -int'($urandom_range(1, 32768));
            cy = int'($urandom_range(0, 65535)) - 32768;
          end
          1: begin
            cx = int'($urandom_range(32767, ew));
            cy = int'($urandom_range(0, 65535)) - 32768;
          end
          default: begin
            cx = int'($urandom_range(0, 65535)) - 32768;
            cy = int'($urandom_range(32767, eh));
          end
        endcase
      end
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // Small window at the origin, reaching just past narrow screens.
          cx = int'($urandom_range(0, (ew < 24) ? ew : 24));
          cy = int'($urandom_range(0, (eh < 16) ? eh : 16));
        end
        6, 7: begin
          // Either side of each screen edge.
          cx = ($urandom_range(0, 1) != 0) ? ew - int'($urandom_range(0, 1)) :
                                             -int'($urandom_range(0, 1));
          cy = ($urandom_range(0, 1) != 0) ? eh - int'($urandom_range(0, 1)) :
                                             -int'($urandom_range(0, 1));
        end
        default: begin
          cx = int'($urandom_range(0, 65535)) - 32768;
          cy = int'($urandom_range(0, 65535)) - 32768;
        end
      endcase
    end
    op.x = 16'(cx);
    op.y = 16'(cy);
    return op;
  endfunction

  // Offer one item after a random gap; predict its result once it is accepted.
  task automatic send_op(input pixel_op_t op, input bit known, input pixel_result_t known_res);
    int            gap;
    pixel_result_t predicted;
    gap = no_idle ? 0 : int'($urandom_range(0, MAX_IDLE));
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.cmd         <= op.cmd;
    in_bus.pos_x       <= op.x;
    in_bus.pos_y       <= op.y;
    in_bus.pixel_color <= op.color;
    in_bus.blend_alpha <= op.alpha;
    do @(posedge clk); while (!in_bus.ready);
    predicted = predict_pixel_op(op);
    pending_results.push_back(known ? known_res : predicted);
  endtask

  // Stop offering items and wait until the block has answered all of them.
  task automatic drain_pending();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen_reg(input logic idx, input logic [CFG_W-1:0] value);
    drain_pending();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  scr_width  = value[SW_W-1:0];
      REG_SCREEN_HEIGHT: scr_height = value[SH_W-1:0];
      default: ;
    endcase
  endtask

  // Result receiver: random stalls, a single long hold-off on request.
  initial begin : result_sink
    int stall;
    out_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        stall         = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : int'($urandom_range(0, MAX_IDLE));
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: read_data %h in_bounds %b",
               out_bus.read_data, out_bus.in_bounds);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_bus.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_bus.read_data);
          fail_count++;
        end
        if (out_bus.in_bounds !== want.in_bounds) begin
          $error("in_bounds: expected %b, got %b", want.in_bounds, out_bus.in_bounds);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_seq
    pixel_op_t        op;
    pixel_result_t    known_res;
    logic [CFG_W-1:0] w, h;
    int               i, p, n;
    cycle_count        = 0;
    fail_count         = 0;
    no_idle            = 1'b0;
    long_hold_req      = 1'b0;
    last_drawn_ok      = 1'b0;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.cmd        <= CMD_WRITE;
    in_bus.pos_x      <= '0;
    in_bus.pos_y      <= '0;
    in_bus.pixel_color <= '0;
    in_bus.blend_alpha <= ALPHA_CLEAR;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= REG_SCREEN_WIDTH;
    cfg_bus.data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at the reset screen size.
    for (i = 0; i < $size(DIRECTED_OPS); i++) begin
      op.cmd    = DIRECTED_OPS[i].cmd;
      op.x      = DIRECTED_OPS[i].x;
      op.y      = DIRECTED_OPS[i].y;
      op.color  = DIRECTED_OPS[i].color;
      op.alpha  = DIRECTED_OPS[i].alpha;
      known_res.read_data = DIRECTED_OPS[i].want_data;
      known_res.in_bounds = DIRECTED_OPS[i].want_inb;
      send_op(op, DIRECTED_OPS[i].known, known_res);
    end

    // Random phases, each under its own screen size.
    for (p = 0; p < PHASE_COUNT; p++) begin
      if (p < $size(PHASE_W)) begin
        w = PHASE_W[p];
        h = PHASE_H[p];
      end else begin
        w = CFG_W'($urandom_range(1, 64));
        h = CFG_W'($urandom_range(1, 48));
      end
      write_screen_reg(REG_SCREEN_WIDTH, w);
      write_screen_reg(REG_SCREEN_HEIGHT, h);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (p == 1 && n == 40) long_hold_req = 1'b1;
        send_op(random_pixel_op(), 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    drain_pending();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ clipped_pixel_blend_unit_top.f @@
hw/rtl/pbu_pkg.sv
hw/rtl/pbu_if.sv
hw/rtl/pbu_clip.sv
hw/rtl/pbu_store.sv
hw/rtl/pbu_mix.sv
hw/rtl/clipped_pixel_blend_unit_top.sv
sim/clipped_pixel_blend_unit_top_test.sv
